### rtl/wait_for_deadlock_detector_core_assert.svh
// Assertion macros shared by the wait-for deadlock detector RTL.
`ifndef WAIT_FOR_DEADLOCK_DETECTOR_CORE_ASSERT_SVH
`define WAIT_FOR_DEADLOCK_DETECTOR_CORE_ASSERT_SVH

// Implication in the same cycle, sampled on the rising clock edge outside reset.
`define WFDD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication into the following cycle, sampled on the rising clock edge outside reset.
`define WFDD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/wfdd_pkg.sv
// Shared constants, types and command/status structures of the wait-for deadlock detector.
package wfdd_pkg;

   // Table geometry and id width.
   localparam int TABLE_ENTRIES = 16;
   localparam int ID_BITS       = 32;
   localparam int SLOT_BITS     = $clog2(TABLE_ENTRIES);

   typedef logic [SLOT_BITS-1:0]     slot_type;
   typedef logic [ID_BITS-1:0]       id_type;
   typedef logic [TABLE_ENTRIES-1:0] entry_vec_type;

   // Operation codes carried with each request transaction.
   typedef enum logic [1:0] {
      OP_ADD              = 2'd0,
      OP_REMOVE_WAITER    = 2'd1,
      OP_REMOVE_INVOLVING = 2'd2,
      OP_DETECT           = 2'd3
   } opcode_type;

   // Which kind of result the datapath presents for emission.
   typedef enum logic [1:0] {
      RES_MUTATION    = 2'd0,
      RES_VICTIM_MORE = 2'd1,
      RES_VICTIM_LAST = 2'd2,
      RES_EMPTY       = 2'd3
   } res_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load;
      logic        mutate;
      logic        start_load;
      logic        start_adv;
      logic        chase;
      logic        check_begin;
      logic        cycle_step;
      logic        push;
      logic        use_walk;
      logic        emit;
      res_sel_type res_sel;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      opcode_type opcode;
      logic       start_valid;
      logic       start_last;
      logic       next_found;
      logic       chase_done;
      logic       cur_marked;
      logic       cycle_closed;
      logic       pend_valid;
   } dp_status_type;

   // One result transaction.
   typedef struct packed {
      logic   victim_valid;
      id_type victim_id;
      logic   add_rejected;
      logic   last;
   } result_type;

endpackage

### rtl/wfdd_datapath.sv
// Wait-for table, chain-following unit and victim registers of the deadlock detector.
module wfdd_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  wfdd_pkg::opcode_type      opcode,
   input  wfdd_pkg::id_type          waiter_id,
   input  wfdd_pkg::id_type          owner_id,
   input  wfdd_pkg::dp_cmd_type      cmd,
   output wfdd_pkg::dp_status_type   status,
   output wfdd_pkg::result_type      result
);

   // Lowest set bit of an entry vector, as a slot index.
   function automatic wfdd_pkg::slot_type lowest_set(input wfdd_pkg::entry_vec_type vec);
      wfdd_pkg::slot_type idx;
      idx = '0;
      for (int i = wfdd_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = wfdd_pkg::slot_type'(i);
         end
      end
      return idx;
   endfunction

   // Table storage; entries are only read where their valid bit is set.
   wfdd_pkg::entry_vec_type valid_ff, valid_in;
   wfdd_pkg::id_type        waiter_ff [wfdd_pkg::TABLE_ENTRIES];
   wfdd_pkg::id_type        holder_ff [wfdd_pkg::TABLE_ENTRIES];

   // Latched request and walk state.
   wfdd_pkg::opcode_type    op_ff;
   wfdd_pkg::id_type        key_w_ff;
   wfdd_pkg::id_type        key_h_ff;
   wfdd_pkg::slot_type      start_ff;
   wfdd_pkg::slot_type      cur_ff;
   wfdd_pkg::slot_type      walk_ff;
   wfdd_pkg::slot_type      steps_ff;
   wfdd_pkg::entry_vec_type mark_ff;
   wfdd_pkg::id_type        max_ff;
   logic                    pend_valid_ff;
   wfdd_pkg::id_type        pend_ff;

   // Combinational lookups.
   wfdd_pkg::slot_type      src;
   wfdd_pkg::id_type        src_holder;
   wfdd_pkg::id_type        src_waiter;
   wfdd_pkg::entry_vec_type link_hit;
   wfdd_pkg::entry_vec_type w_hit;
   wfdd_pkg::entry_vec_type inv_hit;
   wfdd_pkg::slot_type      next_slot;
   wfdd_pkg::slot_type      wr_slot;
   logic                    wr_en;
   logic                    add_reject;

   // The chain unit follows either the chase pointer or the cycle walker.
   assign src        = cmd.use_walk ? walk_ff : cur_ff;
   assign src_holder = holder_ff[src];
   assign src_waiter = waiter_ff[src];

   // Associative compares against every table entry.
   always_comb begin
      for (int i = 0; i < wfdd_pkg::TABLE_ENTRIES; i++) begin
         link_hit[i] = valid_ff[i] && (waiter_ff[i] == src_holder);
         w_hit[i]    = valid_ff[i] && (waiter_ff[i] == key_w_ff);
         inv_hit[i]  = valid_ff[i] && ((waiter_ff[i] == key_h_ff) ||
                                       (holder_ff[i] == key_h_ff));
      end
   end

   assign next_slot  = lowest_set(link_hit);
   assign add_reject = (op_ff == wfdd_pkg::OP_ADD) && !(|w_hit) && (&valid_ff);
   assign wr_slot    = (|w_hit) ? lowest_set(w_hit) : lowest_set(~valid_ff);
   assign wr_en      = cmd.mutate && (op_ff == wfdd_pkg::OP_ADD) && !add_reject;

   // Next valid bits for the table mutations.
   always_comb begin
      valid_in = valid_ff;
      if (cmd.mutate) begin
         unique case (op_ff)
            wfdd_pkg::OP_ADD: begin
               if (wr_en) begin
                  valid_in[wr_slot] = 1'b1;
               end
            end
            wfdd_pkg::OP_REMOVE_WAITER: begin
               valid_in = valid_ff & ~w_hit;
            end
            wfdd_pkg::OP_REMOVE_INVOLVING: begin
               valid_in = valid_ff & ~inv_hit;
            end
            wfdd_pkg::OP_DETECT: begin
               valid_in = valid_ff;
            end
         endcase
      end
   end

   // Control registers: valid bits, cycle marks and the pending victim flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         mark_ff       <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (cmd.load) begin
            mark_ff       <= '0;
            pend_valid_ff <= 1'b0;
         end else begin
            if (cmd.check_begin) begin
               mark_ff[cur_ff] <= 1'b1;
            end else if (cmd.cycle_step) begin
               mark_ff[walk_ff] <= 1'b1;
            end
            if (cmd.push) begin
               pend_valid_ff <= 1'b1;
            end
         end
      end
   end

   // Table write port for adds.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         waiter_ff[wr_slot] <= key_w_ff;
         holder_ff[wr_slot] <= key_h_ff;
      end
   end

   // Request latch, walk pointers and the running cycle maximum.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= opcode;
         key_w_ff <= waiter_id;
         key_h_ff <= owner_id;
         start_ff <= '0;
      end else if (cmd.start_adv) begin
         start_ff <= start_ff + 1'b1;
      end
      if (cmd.start_load) begin
         cur_ff   <= start_ff;
         steps_ff <= '0;
      end else if (cmd.chase) begin
         cur_ff   <= next_slot;
         steps_ff <= steps_ff + 1'b1;
      end
      if (cmd.check_begin) begin
         max_ff  <= src_waiter;
         walk_ff <= next_slot;
      end else if (cmd.cycle_step) begin
         if (src_waiter > max_ff) begin
            max_ff <= src_waiter;
         end
         walk_ff <= next_slot;
      end
      if (cmd.push) begin
         pend_ff <= max_ff;
      end
   end

   // Status for the controller.
   assign status.opcode       = op_ff;
   assign status.start_valid  = valid_ff[start_ff];
   assign status.start_last   = (start_ff == wfdd_pkg::SLOT_BITS'(wfdd_pkg::TABLE_ENTRIES - 1));
   assign status.next_found   = |link_hit;
   assign status.chase_done   = (steps_ff == wfdd_pkg::SLOT_BITS'(wfdd_pkg::TABLE_ENTRIES - 1));
   assign status.cur_marked   = mark_ff[cur_ff];
   assign status.cycle_closed = (walk_ff == cur_ff);
   assign status.pend_valid   = pend_valid_ff;

   // Result presented for emission.
   always_comb begin
      case (cmd.res_sel)
         wfdd_pkg::RES_MUTATION: begin
            result = '{victim_valid: 1'b0, victim_id: '0, add_rejected: add_reject,
                       last: 1'b1};
         end
         wfdd_pkg::RES_VICTIM_MORE: begin
            result = '{victim_valid: 1'b1, victim_id: pend_ff, add_rejected: 1'b0,
                       last: 1'b0};
         end
         wfdd_pkg::RES_VICTIM_LAST: begin
            result = '{victim_valid: 1'b1, victim_id: pend_ff, add_rejected: 1'b0,
                       last: 1'b1};
         end
         default: begin
            result = '{victim_valid: 1'b0, victim_id: '0, add_rejected: 1'b0,
                       last: 1'b1};
         end
      endcase
   end

endmodule

### rtl/wfdd_ctrl.sv
// Controller state machine that sequences mutations, chain walks and result emission.
module wfdd_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic                     out_free,
   input  wfdd_pkg::dp_status_type  status,
   output wfdd_pkg::dp_cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_START,
      ST_CHASE,
      ST_CHECK,
      ST_CYCLE,
      ST_PUSH,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.opcode == wfdd_pkg::OP_DETECT) begin
               state_in = ST_START;
            end else if (out_free) begin
               cmd.mutate  = 1'b1;
               cmd.emit    = 1'b1;
               cmd.res_sel = wfdd_pkg::RES_MUTATION;
               state_in    = ST_IDLE;
            end
         end
         ST_START: begin
            // Empty slots start no walk.
            if (status.start_valid) begin
               cmd.start_load = 1'b1;
               state_in       = ST_CHASE;
            end else if (status.start_last) begin
               state_in = ST_FINISH;
            end else begin
               cmd.start_adv = 1'b1;
               state_in      = ST_START;
            end
         end
         ST_CHASE: begin
            // A chain that ends on a holder with no edge closes no cycle.
            if (!status.next_found) begin
               if (status.start_last) begin
                  state_in = ST_FINISH;
               end else begin
                  cmd.start_adv = 1'b1;
                  state_in      = ST_START;
               end
            end else begin
               cmd.chase = 1'b1;
               if (status.chase_done) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            // The pointer now sits on a cycle; skip it if already reported.
            if (status.cur_marked) begin
               if (status.start_last) begin
                  state_in = ST_FINISH;
               end else begin
                  cmd.start_adv = 1'b1;
                  state_in      = ST_START;
               end
            end else begin
               cmd.check_begin = 1'b1;
               state_in        = ST_CYCLE;
            end
         end
         ST_CYCLE: begin
            cmd.use_walk = 1'b1;
            if (status.cycle_closed) begin
               state_in = ST_PUSH;
            end else begin
               cmd.cycle_step = 1'b1;
            end
         end
         ST_PUSH: begin
            // A held victim goes out, not last, before the new one replaces it.
            if (!status.pend_valid || out_free) begin
               cmd.push    = 1'b1;
               cmd.emit    = status.pend_valid;
               cmd.res_sel = wfdd_pkg::RES_VICTIM_MORE;
               if (status.start_last) begin
                  state_in = ST_FINISH;
               end else begin
                  cmd.start_adv = 1'b1;
                  state_in      = ST_START;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.emit    = 1'b1;
               cmd.res_sel = status.pend_valid ? wfdd_pkg::RES_VICTIM_LAST
                                               : wfdd_pkg::RES_EMPTY;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/wait_for_deadlock_detector_core.sv
// Top level of the wait-for deadlock detector: controller, datapath and result register.
//
// Request transactions carry an opcode in req_tuser and two transaction ids in req_tdata:
// add an edge, remove a waiter's edge, remove every edge involving an id, or detect.
// Each mutation gives one result transaction; a detect gives one result per distinct
// cycle (its largest id, in table slot order) or one empty result, rsp_tlast on the
// final one. Items are processed one at a time: req_tready is high only while idle.
// A mutation is accepted while idle and its result is written to the output register from
// the decode state, after which the block returns to idle for the next request.
// A detect uses the single chain-following unit, which makes one holder lookup per
// cycle: up to TABLE_ENTRIES steps to reach a cycle from each start slot and up to
// TABLE_ENTRIES more to find its largest id.
// Results sit in an output register; when the receiver stalls, the block waits before
// emitting another, and it accepts a new request while the last result is still held.
// Reset clears the table's valid bits at once, so the table is empty when reset is
// released; no clearing pass is needed.
module wait_for_deadlock_detector_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // [31:0] waiter id, [63:32] holder id
   input  logic [1:0]  req_tuser,  // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [31:0] victim_id
   output logic [1:0]  rsp_tuser,  // [0] victim_valid, [1] add_rejected
   output logic        rsp_tlast   // last
);

   wfdd_pkg::dp_cmd_type    dp_cmd;
   wfdd_pkg::dp_status_type dp_status;
   wfdd_pkg::result_type    dp_result;

   logic             rsp_valid_ff;
   wfdd_pkg::id_type rsp_id_ff;
   logic             rsp_victim_ff;
   logic             rsp_reject_ff;
   logic             rsp_last_ff;
   logic             out_free;

   // The output register can take a result when empty or when being drained.
   assign out_free = !rsp_valid_ff || rsp_tready;

   wfdd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .out_free   (out_free),
      .status     (dp_status),
      .cmd        (dp_cmd)
   );

   wfdd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .opcode    (wfdd_pkg::opcode_type'(req_tuser)),
      .waiter_id (req_tdata[31:0]),
      .owner_id  (req_tdata[63:32]),
      .cmd       (dp_cmd),
      .status    (dp_status),
      .result    (dp_result)
   );

   // Result transaction valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (dp_cmd.emit) begin
         rsp_id_ff     <= dp_result.victim_id;
         rsp_victim_ff <= dp_result.victim_valid;
         rsp_reject_ff <= dp_result.add_rejected;
         rsp_last_ff   <= dp_result.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_id_ff;
   assign rsp_tuser  = {rsp_reject_ff, rsp_victim_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Checks on the block's own logic.
`include "wait_for_deadlock_detector_core_assert.svh"

   `WFDD_ASSERT_NOW(a_no_overwrite, dp_cmd.emit, out_free, "result emitted over a held result")
   `WFDD_ASSERT_NOW(a_victim_not_rejected, rsp_tvalid && rsp_tuser[0], !rsp_tuser[1], "victim result flags a rejected add")
   `WFDD_ASSERT_NOW(a_plain_is_last, rsp_tvalid && !rsp_tuser[0], rsp_tlast && (rsp_tdata == 32'd0), "non-victim result not last or id not zero")
   `WFDD_ASSERT_NEXT(a_one_at_a_time, req_tvalid && req_tready, !req_tready, "request taken while an item is in progress")

endmodule

### sim/tb_top.sv
// Self-checking testbench of the wait-for deadlock detector core.
module tb_top;

   localparam int WALK_STEPS   = 64;    // longest holder chain a walk follows
   localparam int POOL_SIZE    = 20;    // more ids than slots, so the table can fill
   localparam int ITEM_COUNT   = 350;   // requests in the whole run, directed part included
   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int DRAIN_CYCLES = 600;   // a little above the slowest detect
   localparam int STALL_LIMIT  = 5000;  // cycles without any transaction

   // One request transaction, or a marker that makes the sender wait for all results.
   typedef struct {
      logic                 pause;
      wfdd_pkg::opcode_type op;
      wfdd_pkg::id_type     waiter;
      wfdd_pkg::id_type     holder;
   } request_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   // Shadow wait-for table kept by the predictor.
   logic             wf_live   [wfdd_pkg::TABLE_ENTRIES];
   wfdd_pkg::id_type wf_waiter [wfdd_pkg::TABLE_ENTRIES];
   wfdd_pkg::id_type wf_holder [wfdd_pkg::TABLE_ENTRIES];

   request_type          pending_req[$];
   wfdd_pkg::result_type due_rsp[$];
   wfdd_pkg::id_type     id_pool[POOL_SIZE];

   int items_total    = 0;
   int items_accepted = 0;
   int detects_sent   = 0;
   int results_seen   = 0;
   int victims_seen   = 0;
   int rejects_seen   = 0;
   int pauses_done    = 0;
   int error_count    = 0;
   int send_gap       = 0;
   int req_calm       = 0;
   int stall_left     = 0;
   int rsp_calm       = 0;
   int idle_cycles    = 0;

   wait_for_deadlock_detector_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   // Gap length: mostly none or short, a few long, with occasional calm stretches.
   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         calm = $urandom_range(8, 30);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Slot that holds the edge of the given waiter, or -1.
   function automatic int slot_of(wfdd_pkg::id_type id);
      for (int s = 0; s < wfdd_pkg::TABLE_ENTRIES; s++)
         if (wf_live[s] && wf_waiter[s] == id) return s;
      return -1;
   endfunction

   // Follow holders from one slot; when the chain closes, give the largest id on the loop.
   function automatic logic chase_from(int start, output wfdd_pkg::id_type victim);
      wfdd_pkg::id_type trail[WALK_STEPS];
      int               n;
      int               nx;
      wfdd_pkg::id_type cur;
      n = 0;
      cur = wf_waiter[start];
      victim = '0;
      for (int step = 0; step < WALK_STEPS; step++) begin
         for (int k = 0; k < n; k++) begin
            if (trail[k] == cur) begin
               victim = cur;
               for (int j = k; j < n; j++)
                  if (trail[j] > victim) victim = trail[j];
               return 1'b1;
            end
         end
         trail[n] = cur;
         n++;
         nx = slot_of(cur);
         if (nx < 0) return 1'b0;
         cur = wf_holder[nx];
      end
      return 1'b0;
   endfunction

   task automatic expect_rsp(logic vv, wfdd_pkg::id_type id, logic rej, logic fin);
      wfdd_pkg::result_type r;
      r.victim_valid = vv;
      r.victim_id    = id;
      r.add_rejected = rej;
      r.last         = fin;
      due_rsp.insert(due_rsp.size(), r);
   endtask

   // Apply one accepted request to the shadow table and queue the results it must give.
   task automatic model_request(wfdd_pkg::opcode_type op, wfdd_pkg::id_type w,
                                wfdd_pkg::id_type h);
      int               s;
      wfdd_pkg::id_type v;
      wfdd_pkg::id_type found[$];
      logic             dup;
      case (op)
         wfdd_pkg::OP_ADD: begin
            s = slot_of(w);
            if (s < 0) begin
               for (int i = wfdd_pkg::TABLE_ENTRIES - 1; i >= 0; i--)
                  if (!wf_live[i]) s = i;
            end
            if (s < 0) begin
               expect_rsp(1'b0, '0, 1'b1, 1'b1);
            end else begin
               wf_live[s]   = 1'b1;
               wf_waiter[s] = w;
               wf_holder[s] = h;
               expect_rsp(1'b0, '0, 1'b0, 1'b1);
            end
         end
         wfdd_pkg::OP_REMOVE_WAITER: begin
            for (int i = 0; i < wfdd_pkg::TABLE_ENTRIES; i++)
               if (wf_live[i] && wf_waiter[i] == w) wf_live[i] = 1'b0;
            expect_rsp(1'b0, '0, 1'b0, 1'b1);
         end
         wfdd_pkg::OP_REMOVE_INVOLVING: begin
            for (int i = 0; i < wfdd_pkg::TABLE_ENTRIES; i++)
               if (wf_live[i] && (wf_waiter[i] == h || wf_holder[i] == h)) wf_live[i] = 1'b0;
            expect_rsp(1'b0, '0, 1'b0, 1'b1);
         end
         default: begin
            detects_sent++;
            for (int i = 0; i < wfdd_pkg::TABLE_ENTRIES; i++) begin
               if (wf_live[i] && chase_from(i, v)) begin
                  dup = 1'b0;
                  foreach (found[k])
                     if (found[k] == v) dup = 1'b1;
                  if (!dup) found.insert(found.size(), v);
               end
            end
            if (found.size() == 0) expect_rsp(1'b0, '0, 1'b0, 1'b1);
            foreach (found[k])
               expect_rsp(1'b1, found[k], 1'b0, k == found.size() - 1);
         end
      endcase
   endtask

   task automatic push_request(wfdd_pkg::opcode_type op, wfdd_pkg::id_type w,
                               wfdd_pkg::id_type h);
      request_type it;
      it.pause  = 1'b0;
      it.op     = op;
      it.waiter = w;
      it.holder = h;
      pending_req.insert(pending_req.size(), it);
      items_total++;
   endtask

   task automatic push_pause();
      request_type it;
      it.pause  = 1'b1;
      it.op     = wfdd_pkg::OP_DETECT;
      it.waiter = '0;
      it.holder = '0;
      pending_req.insert(pending_req.size(), it);
   endtask

   // Holder of a random edge: usually a known waiter, sometimes any id at all.
   function automatic wfdd_pkg::id_type any_holder();
      if ($urandom_range(0, 4) == 0) return $urandom;
      return id_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s expected %h, got %h", $time, field, want, got);
      end
   endtask

   // Request side: offer queued transactions, predicting each one as it is accepted.
   always @(posedge clock) begin : req_side
      request_type it;
      logic        busy;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         busy = req_tvalid;
         if (req_tvalid && req_tready) begin
            model_request(wfdd_pkg::opcode_type'(req_tuser), req_tdata[31:0],
                          req_tdata[63:32]);
            items_accepted++;
            busy = 1'b0;
         end
         if (!busy) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_req.size() != 0) begin
               if (pending_req[0].pause) begin
                  if (due_rsp.size() == 0) begin
                     void'(pending_req.pop_front());
                     pauses_done++;
                  end
               end else begin
                  it = pending_req.pop_front();
                  req_tdata <= {it.holder, it.waiter};
                  req_tuser <= it.op;
                  send_gap = pick_gap(req_calm);
                  busy = 1'b1;
               end
            end
         end
         req_tvalid <= busy;
      end
   end

   // Result side: check every accepted result transaction and throttle rsp_tready.
   always @(posedge clock) begin : rsp_side
      wfdd_pkg::result_type want;
      logic                 nxt_ready;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (rsp_tuser[0]) victims_seen++;
            if (rsp_tuser[1]) rejects_seen++;
            if (due_rsp.size() == 0) begin
               error_count++;
               $display("%0t: result with none expected: id %h user %b last %b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               want = due_rsp.pop_front();
               compare_field("victim_valid", 32'(want.victim_valid), 32'(rsp_tuser[0]));
               compare_field("victim_id", want.victim_id, rsp_tdata);
               compare_field("add_rejected", 32'(want.add_rejected), 32'(rsp_tuser[1]));
               compare_field("last", 32'(want.last), 32'(rsp_tlast));
            end
            // Twice in the run the receiver stops for a long time so the block backs up.
            if (results_seen == 120 || results_seen == 300) stall_left = HOLD_CYCLES;
            else stall_left = pick_gap(rsp_calm);
         end
         nxt_ready = 1'b1;
         if (stall_left > 0) begin
            stall_left--;
            nxt_ready = 1'b0;
         end
         rsp_tready <= nxt_ready;
      end
   end

   // Watchdog: too long without any transaction on either side ends the run.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("tb_top: errors");
         $finish;
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      int idx[POOL_SIZE];
      int t;
      int j;
      int len;
      int r;
      int n;

      for (int i = 0; i < wfdd_pkg::TABLE_ENTRIES; i++) begin
         wf_live[i]   = 1'b0;
         wf_waiter[i] = '0;
         wf_holder[i] = '0;
      end
      id_pool[0] = 32'h0000_0000;
      id_pool[1] = 32'hFFFF_FFFF;
      id_pool[2] = 32'h0000_0001;
      id_pool[3] = 32'h8000_0000;
      for (int i = 4; i < POOL_SIZE; i++) id_pool[i] = $urandom;

      // Directed part: empty table, self-loop, two-party cycle, overwrite, full table.
      push_request(wfdd_pkg::OP_DETECT, id_pool[0], id_pool[1]);
      push_request(wfdd_pkg::OP_REMOVE_INVOLVING, id_pool[2], id_pool[3]);
      push_request(wfdd_pkg::OP_ADD, id_pool[1], id_pool[1]);
      push_request(wfdd_pkg::OP_ADD, id_pool[0], id_pool[2]);
      push_request(wfdd_pkg::OP_ADD, id_pool[2], id_pool[0]);
      push_request(wfdd_pkg::OP_DETECT, id_pool[1], id_pool[0]);
      push_request(wfdd_pkg::OP_ADD, id_pool[2], id_pool[3]);
      push_request(wfdd_pkg::OP_DETECT, id_pool[3], id_pool[2]);
      push_request(wfdd_pkg::OP_REMOVE_WAITER, id_pool[1], id_pool[0]);
      for (int i = 4; i < 18; i++) push_request(wfdd_pkg::OP_ADD, id_pool[i], id_pool[i + 1]);
      push_request(wfdd_pkg::OP_ADD, id_pool[18], id_pool[4]);
      push_request(wfdd_pkg::OP_DETECT, $urandom, $urandom);
      push_pause();

      // Random part, built from short episodes.
      for (int i = 0; i < POOL_SIZE; i++) idx[i] = i;
      while (items_total < ITEM_COUNT) begin
         for (int i = POOL_SIZE - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = idx[i];
            idx[i] = idx[j];
            idx[j] = t;
         end
         r = $urandom_range(0, 99);
         if (r < 45) begin
            // A ring of waiters, perhaps with a tail leading into it, then a detect.
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++)
               push_request(wfdd_pkg::OP_ADD, id_pool[idx[i]], id_pool[idx[(i + 1) % len]]);
            if ($urandom_range(0, 1))
               push_request(wfdd_pkg::OP_ADD, id_pool[idx[len]],
                            id_pool[idx[$urandom_range(0, len - 1)]]);
            push_request(wfdd_pkg::OP_DETECT, $urandom, $urandom);
            if ($urandom_range(0, 1)) begin
               t = idx[$urandom_range(0, len - 1)];
               push_request($urandom_range(0, 1) ? wfdd_pkg::OP_REMOVE_WAITER
                                                 : wfdd_pkg::OP_REMOVE_INVOLVING,
                            id_pool[t], id_pool[t]);
               push_request(wfdd_pkg::OP_DETECT, $urandom, $urandom);
            end
         end else if (r < 80) begin
            // Noise: any operation on mostly known ids.
            n = $urandom_range(3, 8);
            for (int i = 0; i < n; i++)
               push_request(wfdd_pkg::opcode_type'(2'($urandom_range(0, 3))),
                            id_pool[$urandom_range(0, POOL_SIZE - 1)], any_holder());
         end else if (r < 90) begin
            // Every known id waits on something: the table fills and late adds are refused.
            for (int i = 0; i < POOL_SIZE; i++)
               push_request(wfdd_pkg::OP_ADD, id_pool[idx[i]], any_holder());
            push_request(wfdd_pkg::OP_DETECT, $urandom, $urandom);
         end else begin
            // Every known id departs, which empties the table.
            for (int i = 0; i < POOL_SIZE; i++)
               push_request(wfdd_pkg::OP_REMOVE_INVOLVING, $urandom, id_pool[idx[i]]);
            push_request(wfdd_pkg::OP_DETECT, $urandom, $urandom);
            if ($urandom_range(0, 1)) push_pause();
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (items_accepted < items_total || due_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d requests (%0d detects) and %0d results,", items_accepted,
               detects_sent, results_seen);
      $display("of which %0d named a victim and %0d refused an add; sender drained %0d times.",
               victims_seen, rejects_seen, pauses_done);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

### wait_for_deadlock_detector_core.f
+incdir+rtl
rtl/wfdd_pkg.sv
rtl/wfdd_datapath.sv
rtl/wfdd_ctrl.sv
rtl/wait_for_deadlock_detector_core.sv
sim/tb_top.sv
